// ===== hdl/srg_pkg.sv =====
package srg_pkg;

	localparam int POS_W      = 32;
	localparam int INTV_W     = 24;
	localparam int SPD_W      = 21;
	localparam int SPD_MAG_W  = 20;
	localparam int ACC_W      = 20;
	localparam int RAMP_W     = 32;
	localparam int HALT_W     = 40;
	localparam int DIV_NUM_W  = 40;
	localparam int DIV_DEN_W  = 34;
	localparam int DIV_CNT_W  = 6;
	localparam int MUL_CNT_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_MOVE   = 3'd1;
	localparam logic [2:0] OP_SETPOS = 3'd2;
	localparam logic [2:0] OP_ESTOP  = 3'd3;
	localparam logic [2:0] OP_SOFT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_INTV = 2'd2;

	localparam logic [INTV_W-1:0]    INTV_MAX    = {INTV_W{1'b1}};
	localparam logic [SPD_MAG_W-1:0] US_PER_SEC  = 20'd1000000;
	localparam logic [RAMP_W-1:0]    RAMP_MAX    = 32'h7fff_ffff;

	localparam logic [DIV_CNT_W-1:0] NB_HALT  = 6'd40;
	localparam logic [DIV_CNT_W-1:0] NB_REC   = 6'd25;
	localparam logic [DIV_CNT_W-1:0] NB_SPD   = 6'd20;

	typedef struct packed {
		logic [2:0]              op;
		logic signed [POS_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic                    step_pulse;
		logic                    direction;
		logic                    moving;
		logic signed [POS_W-1:0] position;
		logic [INTV_W-1:0]       interval_us;
	} out_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== hdl/srg_div.sv =====
module srg_div import srg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctl_t             ctl,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output div_sts_t             sts,
	output logic [DIV_NUM_W-1:0] quo
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q, quo_q;
	logic [DIV_DEN_W-1:0] den_q, rem_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W+1:0] diff;
	logic                 ge;

	// numerator arrives left-aligned; one quotient bit per cycle
	assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = !diff[DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

// ===== hdl/stepper_ramp_generator.sv =====
// An item that plans nothing goes to the emit state, which registers its result
// once the output is free. One that plans a step interval runs a shift-add square,
// then as needed 40, 25 and 20 quotient bits in the shared bit-serial divider.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset (arst_n low): position, target, ramp, interval and speed clear, the
// elapsed counter saturates, and the registers return to their defaults.
module stepper_ramp_generator import srg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MUL    = 9'b000000010,
		ST_HALT   = 9'b000000100,
		ST_SOFT   = 9'b000001000,
		ST_DIST   = 9'b000010000,
		ST_DECIDE = 9'b000100000,
		ST_REC    = 9'b001000000,
		ST_SPD    = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t state_q;

	logic [ACC_W-1:0]        acc_q;
	logic [INTV_W-1:0]       min_q, first_q;
	logic signed [POS_W-1:0] pos_q, target_q;
	logic [RAMP_W-1:0]       ramp_q;
	logic [INTV_W-1:0]       intv_q;
	logic [SPD_W-1:0]        spd_q;
	logic                    dir_q, pulse_q, soft_q;
	logic [31:0]             since_q;
	logic [HALT_W-1:0]       halt_q;
	logic [POS_W:0]          dist_q;
	logic [HALT_W-1:0]       mul_a_q, mul_acc_q;
	logic [SPD_MAG_W-1:0]    mul_b_q;
	logic [MUL_CNT_W-1:0]    mul_cnt_q;
	logic                    div_start_q;
	logic                    out_valid_q;
	out_t                    out_q;

	div_ctl_t             div_ctl;
	div_sts_t             div_sts;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;

	logic [ACC_W-1:0]     acc_eff;
	logic [SPD_W-1:0]     spd_neg;
	logic [SPD_MAG_W-1:0] sp_mag;
	logic [31:0]          since_nx;
	logic                 fire;
	logic [HALT_W:0]      soft_n;
	logic signed [HALT_W+1:0] soft_sum, pos_x;
	logic signed [POS_W-1:0]  soft_t;
	logic                 dpos, dneg, ramp_pos, rev, halt_le1;
	logic [POS_W:0]       ndist;
	logic [RAMP_W-1:0]    halt_sat, ramp_dec, ramp_inc;
	logic [DIV_DEN_W-1:0] r4, rmag;
	logic [INTV_W+2:0]    ivn, ivc;

	assign acc_eff  = (acc_q == '0) ? ACC_W'(1) : acc_q;
	assign spd_neg  = ~spd_q + SPD_W'(1);
	assign sp_mag   = spd_q[SPD_W-1] ? spd_neg[SPD_MAG_W-1:0] : spd_q[SPD_MAG_W-1:0];
	assign since_nx = (since_q == 32'hffff_ffff) ? since_q : since_q + 32'd1;
	assign fire     = (intv_q != '0) && (since_nx >= {8'd0, intv_q});

	// soft stop target: one step beyond the stopping distance, saturated
	assign soft_n   = {1'b0, halt_q} + (HALT_W+1)'(1);
	assign pos_x    = (HALT_W+2)'(pos_q);
	assign soft_sum = spd_q[SPD_W-1] ? pos_x - $signed({1'b0, soft_n})
	                                 : pos_x + $signed({1'b0, soft_n});
	always_comb begin
		if (soft_sum > (HALT_W+2)'(32'sh7fff_ffff))
			soft_t = 32'sh7fff_ffff;
		else if (soft_sum < -(HALT_W+2)'(64'sh8000_0000))
			soft_t = -32'sh7fff_ffff - 32'sd1;
		else
			soft_t = soft_sum[POS_W-1:0];
	end

	assign halt_le1 = halt_q <= HALT_W'(1);
	assign dneg     = dist_q[POS_W];
	assign dpos     = !dneg && (dist_q != '0);
	assign ndist    = ~dist_q + (POS_W+1)'(1);
	assign halt_sat = (|halt_q[HALT_W-1:31]) ? RAMP_MAX : {1'b0, halt_q[30:0]};
	assign ramp_pos = !ramp_q[RAMP_W-1] && (ramp_q != '0);
	assign rev      = ramp_pos &&
	                  ((dpos && (halt_q >= {7'd0, dist_q} || !dir_q)) ||
	                   (dneg && (halt_q > {7'd0, ndist} || dir_q)));
	assign ramp_dec = rev ? (~halt_sat + RAMP_W'(1)) : ramp_q;
	assign ramp_inc = (ramp_q == RAMP_MAX) ? ramp_q : ramp_q + RAMP_W'(1);

	// recurrence divisor |4n+1|
	assign r4   = {ramp_q, 2'b01};
	assign rmag = r4[DIV_DEN_W-1] ? (~r4 + DIV_DEN_W'(1)) : r4;

	assign ivn = ramp_q[RAMP_W-1] ? {3'd0, intv_q} + {1'b0, div_quo[INTV_W+1:0]}
	                              : {3'd0, intv_q} - {1'b0, div_quo[INTV_W+1:0]};
	always_comb begin
		ivc = ivn;
		if (ivc < {3'd0, min_q})
			ivc = {3'd0, min_q};
		if (ivc > {3'd0, INTV_MAX})
			ivc = {3'd0, INTV_MAX};
		if (ivc == '0)
			ivc = (INTV_W+3)'(1);
	end

	always_comb begin
		div_ctl.start = div_start_q;
		case (state_q)
			ST_HALT: begin
				div_ctl.nbits = NB_HALT;
				div_num       = mul_acc_q;
				div_den       = {13'd0, acc_eff, 1'b0};
			end
			ST_REC: begin
				div_ctl.nbits = NB_REC;
				div_num       = {intv_q, 1'b0, 15'd0};
				div_den       = rmag;
			end
			default: begin
				div_ctl.nbits = NB_SPD;
				div_num       = {US_PER_SEC, 20'd0};
				div_den       = {10'd0, intv_q};
			end
		endcase
	end

	srg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= ACC_W'(1);
			min_q       <= 24'd1000000;
			first_q     <= 24'd956008;
			pos_q       <= '0;
			target_q    <= '0;
			ramp_q      <= '0;
			intv_q      <= '0;
			spd_q       <= '0;
			dir_q       <= 1'b0;
			pulse_q     <= 1'b0;
			soft_q      <= 1'b0;
			since_q     <= 32'hffff_ffff;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_ACCEL:      acc_q   <= cfg_data[ACC_W-1:0];
					REG_MIN_INTV:   min_q   <= cfg_data[INTV_W-1:0];
					REG_FIRST_INTV: first_q <= cfg_data[INTV_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pulse_q <= 1'b0;
						soft_q  <= 1'b0;
						state_q <= ST_EMIT;
						case (in_data.op)
							OP_TICK: begin
								since_q <= since_nx;
								if (fire) begin
									pos_q   <= pos_q + (dir_q ? 32'sd1 : -32'sd1);
									since_q <= '0;
									pulse_q <= 1'b1;
									state_q <= ST_MUL;
								end
							end
							OP_MOVE: begin
								if (target_q != in_data.value) begin
									target_q <= in_data.value;
									state_q  <= ST_MUL;
								end
							end
							OP_SETPOS: begin
								target_q <= in_data.value;
								pos_q    <= in_data.value;
								ramp_q   <= '0;
								intv_q   <= '0;
								spd_q    <= '0;
							end
							OP_ESTOP: begin
								ramp_q   <= '0;
								intv_q   <= '0;
								spd_q    <= '0;
								target_q <= pos_q;
							end
							OP_SOFT: begin
								if (spd_q != '0) begin
									soft_q  <= 1'b1;
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					if (mul_cnt_q == MUL_CNT_W'(1)) begin
						div_start_q <= 1'b1;
						state_q     <= ST_HALT;
					end
				end
				ST_HALT: begin
					if (div_sts.done)
						state_q <= soft_q ? ST_SOFT : ST_DIST;
				end
				ST_SOFT: begin
					soft_q  <= 1'b0;
					state_q <= ST_EMIT;
					if (soft_t != target_q) begin
						target_q <= soft_t;
						state_q  <= ST_DIST;
					end
				end
				ST_DIST: state_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (dist_q == '0 && halt_le1) begin
						intv_q  <= '0;
						spd_q   <= '0;
						ramp_q  <= '0;
						state_q <= ST_EMIT;
					end else if (ramp_dec == '0) begin
						intv_q      <= (first_q == '0) ? INTV_W'(1) : first_q;
						dir_q       <= dpos;
						ramp_q      <= RAMP_W'(1);
						div_start_q <= 1'b1;
						state_q     <= ST_SPD;
					end else begin
						ramp_q      <= ramp_dec;
						div_start_q <= 1'b1;
						state_q     <= ST_REC;
					end
				end
				ST_REC: begin
					if (div_sts.done) begin
						intv_q      <= ivc[INTV_W-1:0];
						ramp_q      <= ramp_inc;
						div_start_q <= 1'b1;
						state_q     <= ST_SPD;
					end
				end
				ST_SPD: begin
					if (div_sts.done) begin
						spd_q   <= dir_q ? div_quo[SPD_W-1:0] : (~div_quo[SPD_W-1:0] + SPD_W'(1));
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath scratch: square, stopping distance, distance to go, result beat
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mul_a_q   <= {20'd0, sp_mag};
				mul_b_q   <= sp_mag;
				mul_acc_q <= '0;
				mul_cnt_q <= MUL_CNT_W'(SPD_MAG_W);
			end
			ST_MUL: begin
				if (mul_b_q[0])
					mul_acc_q <= mul_acc_q + mul_a_q;
				mul_a_q   <= {mul_a_q[HALT_W-2:0], 1'b0};
				mul_b_q   <= {1'b0, mul_b_q[SPD_MAG_W-1:1]};
				mul_cnt_q <= mul_cnt_q - 1'b1;
			end
			ST_HALT: begin
				if (div_sts.done)
					halt_q <= div_quo;
			end
			ST_DIST: dist_q <= {target_q[POS_W-1], target_q} - {pos_q[POS_W-1], pos_q};
			ST_EMIT: begin
				// hold the waiting beat until the receiver takes it
				if (!out_valid_q || !out_stall) begin
					out_q.step_pulse  <= pulse_q;
					out_q.direction   <= dir_q;
					out_q.moving      <= (spd_q != '0) || (target_q != pos_q);
					out_q.position    <= pos_q;
					out_q.interval_us <= intv_q;
				end
			end
			default: ;
		endcase
	end

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_sts.busy)
		else $error("divider busy while idle");

	a_ramp_has_intv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && ramp_q != '0) |-> intv_q != '0)
		else $error("ramp running with zero interval");

	a_halt_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && intv_q == '0) |-> spd_q == '0)
		else $error("speed nonzero while halted");

	a_div_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> (state_q == ST_HALT || state_q == ST_REC || state_q == ST_SPD))
		else $error("divider started outside a divide state");

endmodule
